FILE: rtl/crld_pkg.sv
// crld_pkg: types and constants for the cluster run list decoder
// no dependencies; used by crld_rsp_if, the output buffer and the top level
package crld_pkg;

   localparam int VCN_W           = 63;
   localparam int LCN_W           = 64;
   localparam int ACC_W           = 64;
   localparam int MAX_FIELD_BYTES = 8;

   localparam logic [3:0] LEN_NIBBLE_MASK = 4'hF;
   localparam logic [VCN_W-1:0] VCN_MAX   = {VCN_W{1'b1}};

   typedef enum logic [1:0] {
      ST_RUN = 2'd0,
      ST_END = 2'd1,
      ST_BAD = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_DONE = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic {
      CSR_START_VCN = 1'b0,
      CSR_STOP_VCN  = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type        status;
      logic [VCN_W-1:0]  run_vcn;
      logic [LCN_W-1:0]  run_lcn;
      logic [VCN_W-1:0]  run_length;
      logic              list_done;
   } rsp_word_type;

endpackage

FILE: rtl/crld_req_if.sv
// crld_req_if: input stream of run list bytes, one byte per word
// no dependencies
interface crld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       list_start;

   modport source (output valid, output data_byte, output list_start, input ready);
   modport sink   (input valid, input data_byte, input list_start, output ready);
endinterface

FILE: rtl/crld_rsp_if.sv
// crld_rsp_if: result stream, one decoded run or list end per word
// depends on crld_pkg for field widths
interface crld_rsp_if;
   import crld_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [VCN_W-1:0] run_vcn;
   logic [LCN_W-1:0] run_lcn;
   logic [VCN_W-1:0] run_length;
   logic             list_done;

   modport source (output valid, output status, output run_vcn, output run_lcn,
                   output run_length, output list_done, input ready);
   modport sink   (input valid, input status, input run_vcn, input run_lcn,
                   input run_length, input list_done, output ready);
endinterface

FILE: rtl/crld_out_buf.sv
// crld_out_buf: two-word result buffer parting the decoder from the receiver
// depends on crld_pkg
module crld_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crld_pkg::rsp_word_type push_word,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_ready,
   output crld_pkg::rsp_word_type out_word
);
   import crld_pkg::*;

   rsp_word_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: rtl/cluster_run_list_decoder_unit.sv
// cluster_run_list_decoder_unit: top level of the mapping pairs run list decoder
// depends on crld_pkg, crld_req_if, crld_rsp_if and crld_out_buf
//
// usage
// req carries the run list one byte per word; list_start marks the header byte
// of a new list and abandons any list in progress. rsp carries one word per
// decoded run (status run), and one word at the end of the list (status end)
// or on a field size above eight bytes (status bad). list_done flags the last
// word of a list, including a run that carries the virtual cluster past stop.
// csr writes load start_vcn (index 0) and stop_vcn (index 1); they must
// be made only while the block is idle; the block itself does not enforce this.
// timing: one byte is taken every cycle while req.ready is high; the decoder
// state updates at the byte's accept edge, and a result is written into the
// output buffer at that same edge and is shown on rsp from there.
// a two-word output buffer holds results; req.ready drops only while both
// words are held by a stalled receiver, and rises again in the cycle after one is taken.
// after reset the decoder waits for list_start and stop_vcn is all ones.
module cluster_run_list_decoder_unit (
   input  logic                      clock,
   input  logic                      reset,
   crld_req_if.sink                  req,
   crld_rsp_if.source                rsp,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [crld_pkg::VCN_W-1:0] csr_data
);
   import crld_pkg::*;

   logic [VCN_W-1:0] start_vcn_ff;
   logic [VCN_W-1:0] stop_vcn_ff;

   phase_type        phase_ff, phase_in;
   logic [3:0]       length_bytes_ff, length_bytes_in;
   logic [3:0]       offset_bytes_ff, offset_bytes_in;
   logic [3:0]       byte_count_ff, byte_count_in;
   logic [ACC_W-1:0] length_accum_ff, length_accum_in;
   logic [ACC_W-1:0] delta_accum_ff, delta_accum_in;
   logic [LCN_W-1:0] current_lcn_ff, current_lcn_in;
   logic [VCN_W-1:0] current_vcn_ff, current_vcn_in;

   phase_type        phase_eff;
   logic [3:0]       lb_eff, ob_eff, pos_eff;
   logic [ACC_W-1:0] len_eff, del_eff;
   logic [LCN_W-1:0] lcn_eff;
   logic [VCN_W-1:0] vcn_eff;

   logic [3:0]       hdr_len, hdr_off;
   logic [3:0]       del_pos;
   logic [ACC_W-1:0] len_new, del_new, del_ext;
   logic [5:0]       sign_idx;
   logic             sign_bit;
   logic [LCN_W-1:0] lcn_sum;
   logic [VCN_W+1:0] vcn_sum;
   logic             past;
   logic [4:0]       total, pos_next;

   logic             accept;
   logic             res_valid;
   rsp_word_type     res_word;
   logic             buf_full;
   rsp_word_type     out_word;

   assign req.ready = !buf_full;
   assign accept    = req.valid && req.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_vcn_ff <= '0;
         stop_vcn_ff  <= VCN_MAX;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_VCN: start_vcn_ff <= csr_data;
            CSR_STOP_VCN:  stop_vcn_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // list start clears state before the byte is decoded
      phase_eff = phase_ff;
      lb_eff    = length_bytes_ff;
      ob_eff    = offset_bytes_ff;
      pos_eff   = byte_count_ff;
      len_eff   = length_accum_ff;
      del_eff   = delta_accum_ff;
      lcn_eff   = current_lcn_ff;
      vcn_eff   = current_vcn_ff;
      if (req.list_start) begin
         phase_eff = PH_HEAD;
         lb_eff    = 4'd0;
         ob_eff    = 4'd0;
         pos_eff   = 4'd0;
         len_eff   = '0;
         del_eff   = '0;
         lcn_eff   = '0;
         vcn_eff   = start_vcn_ff;
      end

      hdr_len = req.data_byte[3:0] & LEN_NIBBLE_MASK;
      hdr_off = req.data_byte[7:4];

      // byte lane insert into the length or delta field
      del_pos = pos_eff - lb_eff;
      for (int k = 0; k < 8; k++) begin
         len_new[8*k +: 8] = len_eff[8*k +: 8];
         del_new[8*k +: 8] = del_eff[8*k +: 8];
         if (pos_eff < lb_eff && pos_eff[2:0] == 3'(k)) begin
            len_new[8*k +: 8] = len_eff[8*k +: 8] | req.data_byte;
         end
         if (!(pos_eff < lb_eff) && del_pos[2:0] == 3'(k)) begin
            del_new[8*k +: 8] = del_eff[8*k +: 8] | req.data_byte;
         end
      end

      // sign extension from the top delta byte
      sign_idx = {ob_eff[2:0] - 3'd1, 3'd7};
      sign_bit = del_new[sign_idx];
      for (int k = 0; k < 8; k++) begin
         del_ext[8*k +: 8] = del_new[8*k +: 8];
         if (ob_eff != 4'd0 && 4'(k) >= ob_eff && sign_bit) begin
            del_ext[8*k +: 8] = 8'hFF;
         end
      end

      lcn_sum  = lcn_eff + del_ext;
      vcn_sum  = {2'b00, vcn_eff} + {1'b0, len_new};
      past     = vcn_sum > {2'b00, stop_vcn_ff};
      total    = {1'b0, lb_eff} + {1'b0, ob_eff};
      pos_next = {1'b0, pos_eff} + 5'd1;

      phase_in        = phase_eff;
      length_bytes_in = lb_eff;
      offset_bytes_in = ob_eff;
      byte_count_in   = pos_eff;
      length_accum_in = len_eff;
      delta_accum_in  = del_eff;
      current_lcn_in  = lcn_eff;
      current_vcn_in  = vcn_eff;
      res_valid       = 1'b0;
      res_word        = '0;

      case (phase_eff)
         PH_HEAD: begin
            if (hdr_len == 4'd0) begin
               phase_in           = PH_DONE;
               res_valid          = 1'b1;
               res_word.status    = ST_END;
               res_word.list_done = 1'b1;
            end else if (hdr_len > 4'(MAX_FIELD_BYTES) || hdr_off > 4'(MAX_FIELD_BYTES)) begin
               phase_in           = PH_DONE;
               res_valid          = 1'b1;
               res_word.status    = ST_BAD;
               res_word.list_done = 1'b1;
            end else begin
               phase_in        = PH_BODY;
               length_bytes_in = hdr_len;
               offset_bytes_in = hdr_off;
               byte_count_in   = 4'd0;
               length_accum_in = '0;
               delta_accum_in  = '0;
            end
         end
         PH_BODY: begin
            length_accum_in = len_new;
            delta_accum_in  = del_new;
            if (pos_next < total) begin
               byte_count_in = pos_next[3:0];
            end else begin
               current_lcn_in      = lcn_sum;
               current_vcn_in      = (vcn_sum[VCN_W+1:VCN_W] != 2'b00) ?
                                     VCN_MAX : vcn_sum[VCN_W-1:0];
               byte_count_in       = 4'd0;
               length_accum_in     = '0;
               delta_accum_in      = '0;
               phase_in            = past ? PH_DONE : PH_HEAD;
               res_valid           = 1'b1;
               res_word.status     = ST_RUN;
               res_word.run_vcn    = vcn_eff;
               res_word.run_lcn    = lcn_sum;
               res_word.run_length = len_new[VCN_W-1:0];
               res_word.list_done  = past;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_DONE;
         length_bytes_ff <= 4'd0;
         offset_bytes_ff <= 4'd0;
         byte_count_ff   <= 4'd0;
         length_accum_ff <= '0;
         delta_accum_ff  <= '0;
         current_lcn_ff  <= '0;
         current_vcn_ff  <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         length_bytes_ff <= length_bytes_in;
         offset_bytes_ff <= offset_bytes_in;
         byte_count_ff   <= byte_count_in;
         length_accum_ff <= length_accum_in;
         delta_accum_ff  <= delta_accum_in;
         current_lcn_ff  <= current_lcn_in;
         current_vcn_ff  <= current_vcn_in;
      end
   end

   crld_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_word (res_word),
      .full      (buf_full),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (out_word)
   );

   assign rsp.status     = out_word.status;
   assign rsp.run_vcn    = out_word.run_vcn;
   assign rsp.run_lcn    = out_word.run_lcn;
   assign rsp.run_length = out_word.run_length;
   assign rsp.list_done  = out_word.list_done;

   a_end_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_RUN |->
         rsp.run_vcn == '0 && rsp.run_lcn == '0 && rsp.run_length == '0)
      else $error("end or error word carries run fields");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_RUN |-> rsp.list_done)
      else $error("end or error word without list_done");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |->
         {1'b0, byte_count_ff} < {1'b0, length_bytes_ff} + {1'b0, offset_bytes_ff})
      else $error("byte count beyond run field sizes");

   a_body_sizes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> length_bytes_ff != 4'd0 &&
         length_bytes_ff <= 4'(MAX_FIELD_BYTES) && offset_bytes_ff <= 4'(MAX_FIELD_BYTES))
      else $error("field sizes out of range while collecting a run");

endmodule
